// ===== design/u16u8_pkg.sv =====
package u16u8_pkg;

	typedef enum logic [1:0] {
		JOB_NONE,
		JOB_CP,
		JOB_TERM
	} job_kind_t;

	// One queued item of work: an optional flushed high surrogate,
	// then a code point to encode, the terminator, or nothing.
	typedef struct packed {
		logic        flush_v;
		logic [9:0]  flush_bits;
		job_kind_t   kind;
		logic [20:0] cp;
		logic [31:0] total;
	} job_t;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] SURR_END   = 16'hE000;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [5:0]  HIGH_TAG   = 6'b110110;
	localparam logic [2:0]  FLUSH_LEN  = 3'd3;

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp > 21'h00FFFF)
			n = 3'd4;
		else if (cp > 21'h0007FF)
			n = 3'd3;
		else if (cp > 21'h00007F)
			n = 3'd2;
		else
			n = 3'd1;
		return n;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
			input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (len)
			3'd4: begin
				case (idx)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd3: begin
				case (idx)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			3'd2: begin
				if (idx == 2'd0)
					b = {3'b110, cp[10:6]};
				else
					b = {2'b10, cp[5:0]};
			end
			default: b = cp[7:0];
		endcase
		return b;
	endfunction

endpackage

// ===== design/utf16_to_utf8_encoder.sv =====
// Path: the first byte of an item passes the job queue, then the output register, before it is
// on the result ports, when no earlier job is still queued ahead of it and the output is free.
// Throughput: one byte per cycle from the byte emitter while pop keeps the output free; an item
// makes 0 to 6 bytes there, 1 to 4 for ordinary units, so its byte count sets the sustained rate.
// A queue of QUEUE_DEPTH jobs lets the front keep taking items while bytes drain.
// Reset (arst_n low, asynchronous): no surrogate held, byte count zero, queue and output empty.
module utf16_to_utf8_encoder #(
	parameter int COUNT_WIDTH = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        is_terminator,
	output logic [31:0] total_bytes
);
	import u16u8_pkg::*;

	job_t fr_job;
	job_t hd_job;
	logic fr_push;
	logic q_full;
	logic q_empty;
	logic q_pop;

	u16u8_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.code_unit (code_unit),
		.q_full    (q_full),
		.job_push  (fr_push),
		.job       (fr_job)
	);

	u16u8_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (fr_push),
		.wr_job (fr_job),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_job (hd_job),
		.empty  (q_empty)
	);

	u16u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (hd_job),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.is_terminator (is_terminator),
		.total_bytes   (total_bytes)
	);

	assign full = q_full;

	// the terminator is a lone zero byte closing its item
	a_term_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_terminator |-> out_byte == 8'h00 && last_of_run)
		else $error("terminator item malformed");

	a_total_only_on_term: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !is_terminator |-> total_bytes == 32'd0)
		else $error("byte count shown on a non-terminator item");

	// an item never ends on a multi-byte lead byte
	a_last_not_lead: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && last_of_run |-> out_byte[7:6] != 2'b11)
		else $error("item ends on a lead byte");

	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("job queue popped while empty");

endmodule

// ===== design/u16u8_front.sv =====
module u16u8_front #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [15:0]           code_unit,
	input  logic                  q_full,
	output logic                  job_push,
	output u16u8_pkg::job_t       job
);
	import u16u8_pkg::*;

	logic                   pend_q;
	logic [9:0]             held_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   accept;
	logic                   is_low;
	logic                   is_high;
	logic                   is_zero;
	logic                   pair;
	logic [2:0]             flush_n;
	logic [2:0]             main_n;
	logic [COUNT_WIDTH:0]   sum;
	logic [COUNT_WIDTH-1:0] sat;
	logic [COUNT_WIDTH-1:0] upper;

	assign accept  = push && !q_full;
	assign is_low  = (code_unit >= LOW_FIRST) && (code_unit < SURR_END);
	assign is_high = (code_unit >= HIGH_FIRST) && (code_unit < LOW_FIRST);
	assign is_zero = (code_unit == 16'h0000);
	assign pair    = pend_q && is_low;

	always_comb begin
		job            = '0;
		job.flush_v    = pend_q && !pair;
		job.flush_bits = held_q;
		main_n         = 3'd0;
		if (pair) begin
			job.kind = JOB_CP;
			job.cp   = SUPP_BASE + {1'b0, held_q, code_unit[9:0]};
			main_n   = 3'd4;
		end else if (is_zero) begin
			job.kind = JOB_TERM;
		end else if (is_high) begin
			job.kind = JOB_NONE;
		end else begin
			job.kind = JOB_CP;
			job.cp   = {5'b0, code_unit};
			main_n   = utf8_len({5'b0, code_unit});
		end
		flush_n = job.flush_v ? FLUSH_LEN : 3'd0;
		// saturating count; chained saturation equals saturation of the sum
		sum   = {1'b0, count_q} + (COUNT_WIDTH+1)'(flush_n) + (COUNT_WIDTH+1)'(main_n);
		sat   = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
		upper = sat >> 32;
		job.total = (upper != '0) ? 32'hFFFF_FFFF : 32'(sat);
		job_push  = accept && (job.flush_v || job.kind != JOB_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			held_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			pend_q  <= !pair && !is_zero && is_high;
			held_q  <= (!pair && !is_zero && is_high) ? code_unit[9:0] : 10'd0;
			count_q <= is_zero && !pair ? '0 : sat;
		end
	end

endmodule

// ===== design/u16u8_queue.sv =====
module u16u8_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  u16u8_pkg::job_t wr_job,
	output logic            full,
	input  logic            rd_en,
	output u16u8_pkg::job_t rd_job,
	output logic            empty
);
	import u16u8_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			slots_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== design/u16u8_back.sv =====
module u16u8_back (
	input  logic            clk,
	input  logic            arst_n,
	input  u16u8_pkg::job_t job,
	input  logic            q_empty,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            is_terminator,
	output logic [31:0]     total_bytes
);
	import u16u8_pkg::*;

	logic        out_v_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        term_q;
	logic [31:0] total_q;
	logic        seg_q;
	logic [1:0]  idx_q;

	logic        in_main;
	logic        is_term;
	logic [20:0] cp_cur;
	logic [2:0]  len_cur;
	logic        seg_last;
	logic        job_last;
	logic        go;

	always_comb begin
		in_main  = seg_q || !job.flush_v;
		is_term  = in_main && job.kind == JOB_TERM;
		cp_cur   = in_main ? job.cp : {5'b0, HIGH_TAG, job.flush_bits};
		if (!in_main)
			len_cur = FLUSH_LEN;
		else if (is_term)
			len_cur = 3'd1;
		else
			len_cur = utf8_len(cp_cur);
		seg_last = (idx_q == 2'(len_cur - 3'd1));
		// a flush with nothing after it ends the item on its own
		job_last = seg_last && (in_main || job.kind == JOB_NONE);
		go       = !q_empty && (!out_v_q || pop);
		q_pop    = go && job_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			seg_q   <= 1'b0;
			idx_q   <= '0;
		end else if (go) begin
			out_v_q <= 1'b1;
			if (job_last) begin
				seg_q <= 1'b0;
				idx_q <= '0;
			end else if (seg_last) begin
				seg_q <= 1'b1;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			byte_q  <= is_term ? 8'h00 : utf8_byte(cp_cur, len_cur, idx_q);
			last_q  <= job_last;
			term_q  <= is_term;
			total_q <= is_term ? job.total : 32'd0;
		end
	end

	assign empty         = !out_v_q;
	assign out_byte      = byte_q;
	assign last_of_run   = last_q;
	assign is_terminator = term_q;
	assign total_bytes   = total_q;

endmodule
